FILE: sv/assert_macros.svh
// Assertion macros shared by the oscillator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define VPO_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vpo assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define VPO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vpo assertion failed");

`endif

FILE: sv/vpo_pkg.sv
// Package for the volt-per-octave sine oscillator: widths, register codes,
// config struct and the elaboration-time table builders. No dependencies.
`timescale 1ns / 1ps

package vpo_pkg;

	// Parameter defaults
	localparam int PHASE_BITS_DEF   = 32;
	localparam int SINE_ENTRIES_DEF = 1024;
	localparam int EXP_ENTRIES_DEF  = 256;

	// Field widths
	localparam int CV_W     = 16;
	localparam int OUT_W    = 16;
	localparam int OFFSET_W = 16;
	localparam int BASE_W   = 28;

	// Config port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFFSET    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_PHASE_STEP = 4'd1;
	localparam logic [BASE_W-1:0]    BASE_RESET          = 28'd25479900;

	// Pitch path: Q5.11 volts, clamped to +/-4 V, offset by 4 octaves
	localparam int FRAC_BITS  = 11;
	localparam int VOLT_LIMIT = 8192;
	localparam int UV_W       = 15;
	localparam int OCT_W      = 4;
	localparam int OCT_MAX    = 8;
	localparam int EXP_W      = 32;
	localparam int PROD_W     = BASE_W + EXP_W;
	localparam int STEP_SHIFT = 34;
	localparam int SHAMT_W    = 6;

	// Sine magnitude, unsigned Q15
	localparam int SINE_W = 15;

	// Q30 constants for table generation
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] LN2_Q30     = 64'd744261118;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic signed [OFFSET_W-1:0] pitch_offset;
		logic [BASE_W-1:0]          base_phase_step;
	} cfg_t;

	// 2^(x/ln2) in Q30 by a degree-14 Taylor series, x in Q30
	function automatic logic [63:0] exp_q30(input logic [63:0] x);
		logic [63:0] sum;
		logic [63:0] term;
		sum  = Q30_ONE;
		term = Q30_ONE;
		for (int n = 1; n <= 14; n++) begin
			term = ((term * x) >> 30) / 64'(n);
			sum  = sum + term;
		end
		return sum;
	endfunction

	// round(32767 * sin(x)), x in Q30 radians over the first quadrant
	function automatic logic [SINE_W-1:0] sine_q15(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        scaled;
		logic signed [63:0] sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = signed'(x);
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n[0]) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > signed'(Q30_ONE)) begin
			sum = signed'(Q30_ONE);
		end
		scaled = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (scaled > 64'd32767) begin
			scaled = 64'd32767;
		end
		return SINE_W'(scaled);
	endfunction

endpackage

FILE: sv/vpo_cv_if.sv
// Pitch input channel: valid/ready with the pitch control voltage.
// Depends on vpo_pkg.
`timescale 1ns / 1ps

interface vpo_cv_if import vpo_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [CV_W-1:0] pitch_cv;

	modport source (output valid, output pitch_cv, input ready);
	modport sink (input valid, input pitch_cv, output ready);
endinterface

FILE: sv/vpo_sine_if.sv
// Sample output channel: valid/ready with the sine sample.
// Depends on vpo_pkg.
`timescale 1ns / 1ps

interface vpo_sine_if import vpo_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] sine_out;

	modport source (output valid, output sine_out, input ready);
	modport sink (input valid, input sine_out, output ready);
endinterface

FILE: sv/vpo_cfg_if.sv
// Register write channel: valid/ready with register index and write data.
// Depends on vpo_pkg.
`timescale 1ns / 1ps

interface vpo_cfg_if import vpo_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/vpo_cfg_regs.sv
// Configuration registers: knob pitch offset and base phase step.
// Depends on vpo_pkg and vpo_cfg_if.
`timescale 1ns / 1ps

module vpo_cfg_regs import vpo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	vpo_cfg_if.sink   cfg,
	output cfg_t      regs
);

	logic signed [OFFSET_W-1:0] pitch_offset_q;
	logic [BASE_W-1:0]          base_step_q;

	// Writes are always taken; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_offset_q <= '0;
			base_step_q    <= BASE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PITCH_OFFSET: begin
					pitch_offset_q <= signed'(cfg.data[OFFSET_W-1:0]);
				end
				REG_BASE_PHASE_STEP: begin
					base_step_q <= cfg.data[BASE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign regs.pitch_offset    = pitch_offset_q;
	assign regs.base_phase_step = base_step_q;

endmodule

FILE: sv/vpo_step_gen.sv
// Pitch-to-phase-step pipeline: clamp, exp2 table with interpolation,
// base-step multiply, octave shift. Depends on vpo_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vpo_step_gen import vpo_pkg::*; #(
	parameter int PHASE_BITS  = PHASE_BITS_DEF,
	parameter int EXP_ENTRIES = EXP_ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [CV_W-1:0] pitch_cv,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [PHASE_BITS-1:0]  step
);

	localparam int EXP_AW = $clog2(EXP_ENTRIES);
	localparam int POS_W  = FRAC_BITS + EXP_AW;
	localparam int INT_W  = EXP_W + FRAC_BITS;
	localparam logic signed [CV_W:0] VLIM   = (CV_W+1)'(VOLT_LIMIT);
	localparam logic [UV_W-1:0]      UV_MAX = UV_W'(2 * VOLT_LIMIT);

	// exp2 table over the fractional octave: base value and slope per entry
	logic [EXP_W-1:0] exp_base_rom  [EXP_ENTRIES];
	logic [EXP_W-1:0] exp_delta_rom [EXP_ENTRIES];

	for (genvar k = 0; k < EXP_ENTRIES; k++) begin : g_exp
		localparam logic [63:0] F0 = (64'(k) << 30) / EXP_ENTRIES;
		localparam logic [63:0] F1 = (64'(k + 1) << 30) / EXP_ENTRIES;
		localparam logic [63:0] E0 = exp_q30((F0 * LN2_Q30) >> 30);
		localparam logic [63:0] E1 = exp_q30((F1 * LN2_Q30) >> 30);
		assign exp_base_rom[k]  = EXP_W'(E0);
		assign exp_delta_rom[k] = EXP_W'(E1 - E0);
	end

	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                  rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic [UV_W-1:0]       uv_s1;
	logic [EXP_W-1:0]      t_s2, d_s2;
	logic [FRAC_BITS-1:0]  r_s2;
	logic [OCT_W-1:0]      oct_s2, oct_s3, oct_s4;
	logic [EXP_W-1:0]      e_s3;
	logic [PROD_W-1:0]     prod_s4;
	logic [PHASE_BITS-1:0] step_s5;

	logic signed [CV_W:0]  v_sum;
	logic [UV_W-1:0]       uv_next;
	logic [POS_W-1:0]      pos;
	logic [EXP_AW-1:0]     exp_idx;
	logic [INT_W-1:0]      interp;
	logic [SHAMT_W-1:0]    shamt;

	// Stage ready: a stage takes new data when empty or when it drains
	assign rdy_s5    = !vld_s5 || out_ready;
	assign rdy_s4    = !vld_s4 || rdy_s5;
	assign rdy_s3    = !vld_s3 || rdy_s4;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign out_valid = vld_s5;
	assign step      = step_s5;

	// Add knob offset, clamp to +/-4 V, shift up by 4 octaves
	always_comb begin
		v_sum = (CV_W+1)'(pitch_cv) + (CV_W+1)'(cfg.pitch_offset);
		if (v_sum > VLIM) begin
			uv_next = UV_MAX;
		end else if (v_sum < -VLIM) begin
			uv_next = '0;
		end else begin
			uv_next = UV_W'(v_sum + VLIM);
		end
	end

	// Table position of the fractional octave
	assign pos     = POS_W'(uv_s1[FRAC_BITS-1:0]) * POS_W'(EXP_ENTRIES);
	assign exp_idx = pos[POS_W-1:FRAC_BITS];

	// Linear interpolation term
	assign interp = INT_W'(d_s2) * INT_W'(r_s2);

	// Whole octaves become a right shift of the product
	assign shamt = SHAMT_W'(STEP_SHIFT) - SHAMT_W'(oct_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			uv_s1 <= uv_next;
		end
		if (vld_s1 && rdy_s2) begin
			t_s2   <= exp_base_rom[exp_idx];
			d_s2   <= exp_delta_rom[exp_idx];
			r_s2   <= pos[FRAC_BITS-1:0];
			oct_s2 <= uv_s1[UV_W-1 -: OCT_W];
		end
		if (vld_s2 && rdy_s3) begin
			e_s3   <= t_s2 + EXP_W'(interp >> FRAC_BITS);
			oct_s3 <= oct_s2;
		end
		if (vld_s3 && rdy_s4) begin
			prod_s4 <= PROD_W'(cfg.base_phase_step) * PROD_W'(e_s3);
			oct_s4  <= oct_s3;
		end
		if (vld_s4 && rdy_s5) begin
			step_s5 <= PHASE_BITS'(prod_s4 >> shamt);
		end
	end

	`VPO_ASSERT_SAME(a_uv_clamped, clk, arst_n, vld_s1, uv_s1 <= UV_MAX)
	`VPO_ASSERT_SAME(a_oct_range, clk, arst_n, vld_s4, oct_s4 <= OCT_W'(OCT_MAX))

endmodule

FILE: sv/vpo_phase_acc.sv
// Wrapping phase accumulator, one register stage.
// Depends on vpo_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vpo_phase_acc import vpo_pkg::*; #(
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PHASE_BITS-1:0] step,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PHASE_BITS-1:0] phase
);

	logic                  vld_q;
	logic [PHASE_BITS-1:0] phase_q;

	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign phase     = phase_q;

	// Phase advances once per transfer and wraps modulo 2^PHASE_BITS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			phase_q <= '0;
		end else if (in_ready) begin
			vld_q <= in_valid;
			if (in_valid) begin
				phase_q <= phase_q + step;
			end
		end
	end

	`VPO_ASSERT_NEXT(a_phase_hold, clk, arst_n, !(in_valid && in_ready), $stable(phase_q))
	`VPO_ASSERT_NEXT(a_valid_after_xfer, clk, arst_n, in_valid && in_ready, out_valid)

endmodule

FILE: sv/vpo_sine_lut.sv
// Quarter-wave sine lookup: index scaling, registered table read, sign.
// Depends on vpo_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vpo_sine_lut import vpo_pkg::*; #(
	parameter int PHASE_BITS   = PHASE_BITS_DEF,
	parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PHASE_BITS-1:0]   phase,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] sine_out
);

	localparam int OFF_W  = PHASE_BITS - 2;
	localparam int SIN_AW = $clog2(SINE_ENTRIES);
	localparam int SIN_RW = $clog2(SINE_ENTRIES + 1);
	localparam int SCL_W  = OFF_W + SIN_AW;
	localparam logic signed [OUT_W-1:0] MOST_NEG = {1'b1, {(OUT_W-1){1'b0}}};

	// Quarter-wave table, SINE_ENTRIES+1 points including both ends
	logic [SINE_W-1:0] sine_rom [SINE_ENTRIES + 1];

	for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_sine
		localparam logic [63:0] X = (64'(k) * HALF_PI_Q30) / SINE_ENTRIES;
		assign sine_rom[k] = sine_q15(X);
	end

	logic                    vld_s1, vld_s2, vld_s3;
	logic                    rdy_s1, rdy_s2, rdy_s3;
	logic [SIN_AW-1:0]       idx_s1;
	logic [1:0]              quad_s1;
	logic [SINE_W-1:0]       mag_s2;
	logic                    neg_s2;
	logic signed [OUT_W-1:0] sine_s3;

	logic [SCL_W-1:0]        scaled;
	logic [SIN_RW-1:0]       rom_addr;

	assign rdy_s3    = !vld_s3 || out_ready;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign out_valid = vld_s3;
	assign sine_out  = sine_s3;

	// Offset inside the quadrant scaled to a table index
	assign scaled = SCL_W'(phase[OFF_W-1:0]) * SCL_W'(SINE_ENTRIES);

	// Odd quadrants read the table mirrored
	assign rom_addr = quad_s1[0] ? (SIN_RW'(SINE_ENTRIES) - SIN_RW'(idx_s1)) : SIN_RW'(idx_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	// Payload registers; the table read is registered in stage 2
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			idx_s1  <= scaled[SCL_W-1:OFF_W];
			quad_s1 <= phase[PHASE_BITS-1 -: 2];
		end
		if (vld_s1 && rdy_s2) begin
			mag_s2 <= sine_rom[rom_addr];
			neg_s2 <= quad_s1[1];
		end
		if (vld_s2 && rdy_s3) begin
			sine_s3 <= neg_s2 ? -$signed({1'b0, mag_s2}) : $signed({1'b0, mag_s2});
		end
	end

	`VPO_ASSERT_SAME(a_no_most_neg, clk, arst_n, vld_s3, sine_s3 != MOST_NEG)

endmodule

FILE: sv/volt_per_octave_sine_oscillator.sv
// Volt-per-octave sine oscillator, top level.
// Nine register stages lie between an input transfer and the result being valid.
// Throughput: one sample per cycle while sine.ready is high; the phase accumulator adds one step per transfer.
// Reset: valids cleared, phase to zero, pitch offset 0, base step 25479900.
// Both tables are constant logic, so no fill or clearing pass after reset.
// Depends on vpo_pkg, the channel interfaces and the vpo_* submodules.
`timescale 1ns / 1ps

module volt_per_octave_sine_oscillator import vpo_pkg::*; #(
	parameter int PHASE_BITS   = PHASE_BITS_DEF,
	parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
	parameter int EXP_ENTRIES  = EXP_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	vpo_cv_if.sink      cv,
	vpo_sine_if.source  sine,
	vpo_cfg_if.sink     cfg
);

	cfg_t                  cfg_vals;
	logic                  step_valid;
	logic                  step_ready;
	logic [PHASE_BITS-1:0] step;
	logic                  phase_valid;
	logic                  phase_ready;
	logic [PHASE_BITS-1:0] phase;

	// Register file
	vpo_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_vals)
	);

	// Pitch to phase step
	vpo_step_gen #(
		.PHASE_BITS  (PHASE_BITS),
		.EXP_ENTRIES (EXP_ENTRIES)
	) u_step_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_vals),
		.in_valid  (cv.valid),
		.in_ready  (cv.ready),
		.pitch_cv  (cv.pitch_cv),
		.out_valid (step_valid),
		.out_ready (step_ready),
		.step      (step)
	);

	// Phase accumulator
	vpo_phase_acc #(
		.PHASE_BITS (PHASE_BITS)
	) u_phase_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (step_valid),
		.in_ready  (step_ready),
		.step      (step),
		.out_valid (phase_valid),
		.out_ready (phase_ready),
		.phase     (phase)
	);

	// Phase to sample
	vpo_sine_lut #(
		.PHASE_BITS   (PHASE_BITS),
		.SINE_ENTRIES (SINE_ENTRIES)
	) u_sine_lut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (phase_valid),
		.in_ready  (phase_ready),
		.phase     (phase),
		.out_valid (sine.valid),
		.out_ready (sine.ready),
		.sine_out  (sine.sine_out)
	);

endmodule

FILE: verif/tb_top.sv
// Testbench for the volt-per-octave sine oscillator: a directed table, then random phases
// checked against a bit-accurate predictor of the pitch, phase and sine path.
// Depends on vpo_pkg, the vpo_*_if channel interfaces and the oscillator RTL.
`timescale 1ns / 1ps

module tb_top import vpo_pkg::*; ();

	localparam int EXP_N           = 256;
	localparam int SINE_N          = 1024;
	localparam longint unsigned Q30        = 64'd1073741824;
	localparam longint unsigned LN2_FX     = 64'd744261118;
	localparam longint unsigned HALF_PI_FX = 64'd1686629713;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd15;
	localparam int HOLD_CYCLES     = 64;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int TAIL_CYCLES     = 20;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 110;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [CFG_IDX_W-1:0]    index;
		logic [CFG_DATA_W-1:0]   data;
		logic signed [CV_W-1:0]  cv;
		logic                    known;
		logic signed [OUT_W-1:0] sample;
	} stim_row_t;

	// Directed rows: a zero step keeps the phase at zero, so those samples are known
	localparam stim_row_t DIR_ROWS [24] = '{
		'{ROW_WRITE,  REG_BASE_PHASE_STEP, 32'hF000_0000, 16'sd0,     1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'sh7FFF,  1'b1, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'sh8000,  1'b1, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'sd0,     1'b1, 16'sd0},
		'{ROW_WRITE,  REG_UNMAPPED,        32'h0FFF_FFFF, 16'sd0,     1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'sh1234,  1'b1, 16'sd0},
		'{ROW_WRITE,  REG_PITCH_OFFSET,    32'h0000_7FFF, 16'sd0,     1'b0, 16'sd0},
		'{ROW_WRITE,  REG_BASE_PHASE_STEP, 32'hFFFF_FFFF, 16'sd0,     1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'sh8000,  1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'sh7FFF,  1'b0, 16'sd0},
		'{ROW_WRITE,  REG_PITCH_OFFSET,    32'hFFFF_8000, 16'sd0,     1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'sh7FFF,  1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'sh8000,  1'b0, 16'sd0},
		'{ROW_WRITE,  REG_PITCH_OFFSET,    32'hABCD_0000, 16'sd0,     1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'sh2000,  1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'shE000,  1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'sh1FFF,  1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'shE001,  1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'sh0001,  1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'shFFFF,  1'b0, 16'sd0},
		'{ROW_WRITE,  REG_BASE_PHASE_STEP, {4'hA, BASE_RESET}, 16'sd0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'sd0,     1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'sh0800,  1'b0, 16'sd0},
		'{ROW_SAMPLE, REG_PITCH_OFFSET,    32'h0,         16'shF800,  1'b0, 16'sd0}
	};

	logic clk;
	logic arst_n;

	vpo_cv_if   cv_ch ();
	vpo_sine_if sine_ch ();
	vpo_cfg_if  cfg_ch ();

	volt_per_octave_sine_oscillator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cv     (cv_ch),
		.sine   (sine_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: tables, register copies and the phase accumulator
	logic [63:0]                exp2_q30 [0:EXP_N];
	logic [14:0]                quarter_sine [0:SINE_N];
	logic signed [OFFSET_W-1:0] knob_offset;
	logic [BASE_W-1:0]          c4_step;
	logic [31:0]                phase_acc;
	logic signed [OUT_W-1:0]    expected_samples [$];

	int unsigned mismatches   = 0;
	int unsigned samples_seen = 0;
	int unsigned items_sent   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned ready_stall  = 0;
	bit          calm         = 1'b0;
	bit          hold_req     = 1'b0;
	bit          hold_taken   = 1'b0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Idle bursts are allowed in three quarters of every 128 transfers, never at the end
	function automatic bit idling_allowed(input int unsigned count);
		return !calm && (count % 128) < 96;
	endfunction

	// One sample tick: clamp, exp2 step, accumulate, quarter-wave lookup
	function automatic logic signed [OUT_W-1:0] advance_oscillator(
		input logic signed [CV_W-1:0] cv_in);
		int          volts;
		logic [14:0] uv;
		int          octave4;
		int          seg;
		logic [63:0] r;
		logic [63:0] e;
		logic [63:0] prod;
		logic [9:0]  idx;
		int          mag;
		volts = int'(cv_in) + int'(knob_offset);
		if (volts > VOLT_LIMIT) begin
			volts = VOLT_LIMIT;
		end
		if (volts < -VOLT_LIMIT) begin
			volts = -VOLT_LIMIT;
		end
		// offset by four octaves so the whole octave count is never negative
		uv      = 15'(volts + VOLT_LIMIT);
		octave4 = int'(uv[14:11]);
		seg     = int'(uv[10:3]);
		r       = 64'(uv[2:0]) << 8;
		e       = exp2_q30[seg] + (((exp2_q30[seg + 1] - exp2_q30[seg]) * r) >> 11);
		prod    = 64'(c4_step) * e;
		phase_acc = phase_acc + 32'(prod >> (34 - octave4));
		// quadrant from the top two bits, mirrored in odd quadrants, negated in the upper half of the phase range
		idx = phase_acc[29:20];
		mag = phase_acc[30] ? int'(quarter_sine[SINE_N - int'(idx)]) : int'(quarter_sine[idx]);
		if (phase_acc[31]) begin
			mag = -mag;
		end
		return 16'(mag);
	endfunction

	// Offer one pitch value, with an optional idle burst first; predict on transfer
	task automatic push_pitch(input logic signed [CV_W-1:0] cv_val, input logic known,
		input logic signed [OUT_W-1:0] typed);
		logic signed [OUT_W-1:0] predicted;
		if (idling_allowed(items_sent) && $urandom_range(0, 4) == 0) begin
			cv_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		cv_ch.valid    <= 1'b1;
		cv_ch.pitch_cv <= cv_val;
		@(posedge clk);
		while (!cv_ch.ready) @(posedge clk);
		predicted = advance_oscillator(cv_val);
		expected_samples.push_back(known ? typed : predicted);
		items_sent++;
	endtask

	// Register write; the predictor copy follows only the mapped indexes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_PITCH_OFFSET: begin
				knob_offset = value[OFFSET_W-1:0];
			end
			REG_BASE_PHASE_STEP: begin
				c4_step = value[BASE_W-1:0];
			end
			default: begin
			end
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering and wait for every predicted sample to come back
	task automatic settle();
		cv_ch.valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
	endtask

	// Sample checker and output-side back-pressure
	always @(posedge clk) begin
		logic signed [OUT_W-1:0] want;
		if (arst_n && sine_ch.valid && sine_ch.ready) begin
			samples_seen++;
			if (expected_samples.size() == 0) begin
				mismatches++;
				$display("%0t: sine_out %0d with no sample pending", $time, sine_ch.sine_out);
			end else begin
				want = expected_samples.pop_front();
				if (sine_ch.sine_out !== want) begin
					mismatches++;
					$display("%0t: sine_out mismatch: expected %0d, actual %0d",
						$time, want, sine_ch.sine_out);
				end
			end
		end
		if (hold_req && !hold_taken) begin
			// long hold-off so the pipeline fills and stalls the pitch input
			hold_taken  = 1'b1;
			ready_stall = HOLD_CYCLES;
		end else if (ready_stall == 0 && idling_allowed(samples_seen)
			&& $urandom_range(0, 5) == 0) begin
			ready_stall = $urandom_range(1, 3);
		end
		if (ready_stall != 0) begin
			ready_stall--;
			sine_ch.ready <= 1'b0;
		end else begin
			sine_ch.ready <= 1'b1;
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((cv_ch.valid && cv_ch.ready) || (sine_ch.valid && sine_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		longint unsigned         f;
		longint unsigned         x;
		longint unsigned         x2;
		longint unsigned         sum;
		longint unsigned         term;
		longint unsigned         scaled;
		longint                  ssum;
		logic [31:0]             rnd;
		logic signed [CV_W-1:0]  cv_val;
		logic signed [OFFSET_W-1:0] off;
		logic [BASE_W-1:0]       base;

		arst_n         <= 1'b0;
		cv_ch.valid    <= 1'b0;
		cv_ch.pitch_cv <= '0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.index   <= '0;
		cfg_ch.data    <= '0;
		knob_offset = '0;
		c4_step     = BASE_RESET;
		phase_acc   = '0;

		// exp2 over one octave in Q30, Taylor series of e^(f*ln2)
		for (int k = 0; k <= EXP_N; k++) begin
			f    = (64'(k) << 30) / 64'(EXP_N);
			x    = (f * LN2_FX) >> 30;
			sum  = Q30;
			term = Q30;
			for (int n = 1; n <= 14; n++) begin
				term = ((term * x) >> 30) / 64'(n);
				sum  = sum + term;
			end
			exp2_q30[k] = sum;
		end

		// quarter-wave sine, rounded to 15 bits
		for (int k = 0; k <= SINE_N; k++) begin
			x    = (64'(k) * HALF_PI_FX) / 64'(SINE_N);
			x2   = (x * x) >> 30;
			term = x;
			ssum = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					ssum = ssum - longint'(term);
				end else begin
					ssum = ssum + longint'(term);
				end
			end
			if (ssum < 0) begin
				ssum = 0;
			end
			if (ssum > longint'(Q30)) begin
				ssum = longint'(Q30);
			end
			scaled = (64'(ssum) * 64'd32767 + (64'd1 << 29)) >> 30;
			if (scaled > 64'd32767) begin
				scaled = 64'd32767;
			end
			quarter_sine[k] = 15'(scaled);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < $size(DIR_ROWS); i++) begin
			if (DIR_ROWS[i].kind == ROW_WRITE) begin
				settle();
				write_reg(DIR_ROWS[i].index, DIR_ROWS[i].data);
			end else begin
				push_pitch(DIR_ROWS[i].cv, DIR_ROWS[i].known, DIR_ROWS[i].sample);
			end
		end

		// Random phases, each with its own register setting
		for (int p = 0; p < PHASES; p++) begin
			settle();
			calm = (p == PHASES - 1);
			case (p)
				0: begin
					off  = '0;
					base = '1;
				end
				1: begin
					off  = 16'sh7FFF;
					base = BASE_W'($urandom);
				end
				3: begin
					off  = 16'sh8000;
					base = '1;
				end
				4: begin
					off  = 16'(int'($urandom_range(0, 4096)) - 2048);
					base = BASE_W'($urandom_range(0, 65535));
				end
				5: begin
					off  = 16'($urandom);
					base = BASE_W'($urandom);
				end
				PHASES - 1: begin
					off  = '0;
					base = BASE_RESET;
				end
				default: begin
					off  = 16'(int'($urandom_range(0, 4096)) - 2048);
					base = BASE_W'($urandom);
				end
			endcase
			// junk in the upper data bits must be dropped
			rnd = $urandom;
			write_reg(REG_PITCH_OFFSET, {rnd[31:16], off});
			write_reg(REG_BASE_PHASE_STEP, {rnd[31:28], base});
			if ($urandom_range(0, 2) == 0) begin
				write_reg(CFG_IDX_W'($urandom_range(REG_BASE_PHASE_STEP + 1, REG_UNMAPPED)),
					$urandom);
			end
			if (p == 2) begin
				hold_req = 1'b1;
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						cv_val = 16'(int'($urandom_range(0, 2 * VOLT_LIMIT)) - VOLT_LIMIT);
					end
					6, 7: begin
						cv_val = 16'($urandom);
					end
					8: begin
						case ($urandom_range(0, 3))
							0: cv_val = 16'sh7FFF;
							1: cv_val = 16'sh8000;
							2: cv_val = 16'(VOLT_LIMIT);
							default: cv_val = 16'(-VOLT_LIMIT);
						endcase
					end
					default: begin
						// whole octaves and their neighbors
						cv_val = 16'(2048 * (int'($urandom_range(0, 8)) - 4)
							+ int'($urandom_range(0, 2)) - 1);
					end
				endcase
				push_pitch(cv_val, 1'b0, '0);
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_samples.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/vpo_pkg.sv
sv/vpo_cv_if.sv
sv/vpo_sine_if.sv
sv/vpo_cfg_if.sv
sv/vpo_cfg_regs.sv
sv/vpo_step_gen.sv
sv/vpo_phase_acc.sv
sv/vpo_sine_lut.sv
sv/volt_per_octave_sine_oscillator.sv
verif/tb_top.sv
